// File: rtl/core/csg_pkg.sv
// Shared types, constants and the gamma curve table for the cross sharpen block.
`default_nettype none
package csg_pkg;

  localparam int unsigned DEF_MAX_WIDTH = 2048;
  localparam logic [11:0] FRAME_WIDTH_RST = 12'd640;
  localparam logic [15:0] FRAME_HEIGHT_RST = 16'd480;

  localparam logic CFG_FRAME_WIDTH = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  localparam int unsigned OFIFO_DEPTH = 3;
  localparam int unsigned OFIFO_CW = $clog2(OFIFO_DEPTH + 1);
  localparam int unsigned OFIFO_PW = $clog2(OFIFO_DEPTH);

  typedef struct packed {
    logic       req_type;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [10:0] column_out;
    logic [15:0] row_out;
    logic        frame_end;
  } pix_out_t;

  typedef struct packed {
    logic        emit;
    logic        wr_upper;
    logic        flush;
    logic        last;
    logic        x_zero;
    logic        row_zero;
    logic        fwd;
    logic        frame_end;
    logic [15:0] row;
  } s1_ctl_t;

  typedef logic [7:0] gamma_rom_t [256];

  // entry i is the largest v with 255 * v^5 <= i^6
  function automatic gamma_rom_t build_gamma_rom();
    gamma_rom_t rom;
    logic [63:0] v;
    logic [63:0] n;
    logic [63:0] i6;
    v = 64'd0;
    for (int i = 0; i < 256; i++) begin
      i6 = 64'(i) * 64'(i) * 64'(i) * 64'(i) * 64'(i) * 64'(i);
      n = v + 64'd1;
      while ((v < 64'd255) && ((64'd255 * n * n * n * n * n) <= i6)) begin
        v = n;
        n = v + 64'd1;
      end
      rom[i] = v[7:0];
    end
    return rom;
  endfunction

  localparam gamma_rom_t GAMMA_ROM = build_gamma_rom();

endpackage
`default_nettype wire

// File: rtl/core/cross_sharpen_gamma_curve.sv
// Top level: RGB cross stencil sharpen with gamma curve over a raster stream.
// Throughput: one word per cycle while the result queue has room; the middle line
// store is kept in two copies so the center and right neighbors are read in the
// same cycle. Results pass through the stage 1 registers and the result queue.
// Results lag the input by one row; flush words drain the last row. Reset clears
// counters, queue pointers, the stage 1 valid flag and left_q, not line stores.
`default_nettype none
module cross_sharpen_gamma_curve #(
  parameter int unsigned MAX_WIDTH = csg_pkg::DEF_MAX_WIDTH
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire csg_pkg::pix_in_t   in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output csg_pkg::pix_out_t       out_data_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic               cfg_index_i,
  input  wire logic [15:0]        cfg_data_i
);

  import csg_pkg::*;

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WBITS = ($clog2(MAX_WIDTH + 1) > 12) ? $clog2(MAX_WIDTH + 1) : 12;

  logic [11:0]    fw_q;
  logic [15:0]    fh_q;
  logic [WBITS-1:0] fw_ext, w_eff;
  logic [15:0]    h_eff;

  logic [AW-1:0]  col_q, col_d;
  logic [AW-1:0]  drain_q, drain_d;
  logic [15:0]    row_q, row_d;

  logic           in_fire, is_flush, pending, act_flush, act_pix, last0, fwd0;
  logic [AW-1:0]  x0;
  logic [23:0]    px0;

  logic           s1_vld_q;
  s1_ctl_t        s1_ctl_q, s1_ctl_d;
  logic [AW-1:0]  s1_x_q;
  logic [23:0]    s1_px_q;
  logic [23:0]    fwd_data_q;
  logic [23:0]    left_q;

  logic [23:0]    mid_a_rd, mid_b_rd, up_rd;
  logic [23:0]    c1, l1, r1, u1, d1;
  logic [23:0]    y1;
  logic           push;
  pix_out_t       res_word;
  logic [OFIFO_CW-1:0] fifo_cnt;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= FRAME_WIDTH_RST;
      fh_q <= FRAME_HEIGHT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FRAME_WIDTH: fw_q <= cfg_data_i[11:0];
        CFG_FRAME_HEIGHT: fh_q <= cfg_data_i;
        default: fw_q <= fw_q;
      endcase
    end
  end

  always_comb begin
    fw_ext = WBITS'(fw_q);
    if (fw_q == 12'd0) begin
      w_eff = WBITS'(1);
    end else if (fw_ext > WBITS'(MAX_WIDTH)) begin
      w_eff = WBITS'(MAX_WIDTH);
    end else begin
      w_eff = fw_ext;
    end
    h_eff = (fh_q == 16'd0) ? 16'd1 : fh_q;
  end

  // stage 0: decode the accepted word, issue line store reads
  assign in_fire = in_valid_i && in_ready_o;
  assign is_flush = in_data_i.req_type;
  assign pending = (row_q >= h_eff);
  assign act_flush = is_flush && pending;
  assign act_pix = !is_flush && !pending;
  assign x0 = is_flush ? drain_q : col_q;
  assign last0 = ((WBITS'(x0) + WBITS'(1)) >= w_eff);
  assign px0 = {in_data_i.blue_in, in_data_i.green_in, in_data_i.red_in};
  assign fwd0 = s1_vld_q && s1_ctl_q.wr_upper && (s1_x_q == x0);

  always_comb begin
    col_d = col_q;
    drain_d = drain_q;
    row_d = row_q;
    if (act_flush) begin
      if (last0) begin
        row_d = '0;
        drain_d = '0;
        col_d = '0;
      end else begin
        drain_d = x0 + 1'b1;
      end
    end else if (act_pix) begin
      if (last0) begin
        col_d = '0;
        row_d = row_q + 16'd1;
        drain_d = '0;
      end else begin
        col_d = x0 + 1'b1;
      end
    end
  end

  always_comb begin
    s1_ctl_d.emit = act_flush || (act_pix && (row_q != 16'd0));
    s1_ctl_d.wr_upper = act_pix;
    s1_ctl_d.flush = is_flush;
    s1_ctl_d.last = last0;
    s1_ctl_d.x_zero = (x0 == '0);
    s1_ctl_d.row_zero = (row_q == 16'd1);
    s1_ctl_d.fwd = fwd0;
    s1_ctl_d.frame_end = act_flush && last0;
    s1_ctl_d.row = row_q - 16'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      drain_q <= '0;
      row_q <= '0;
      s1_vld_q <= 1'b0;
      left_q <= '0;
    end else begin
      s1_vld_q <= in_fire && (act_flush || act_pix);
      if (in_fire) begin
        col_q <= col_d;
        drain_q <= drain_d;
        row_q <= row_d;
      end
      if (push) begin
        left_q <= c1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_ctl_q <= s1_ctl_d;
      s1_x_q <= x0;
      s1_px_q <= px0;
      fwd_data_q <= c1;
    end
  end

  csg_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_mid_a (
    .clk_i   (clk_i),
    .we_i    (in_fire && act_pix),
    .waddr_i (x0),
    .wdata_i (px0),
    .re_i    (in_fire),
    .raddr_i (x0),
    .rdata_o (mid_a_rd)
  );

  csg_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_mid_b (
    .clk_i   (clk_i),
    .we_i    (in_fire && act_pix),
    .waddr_i (x0),
    .wdata_i (px0),
    .re_i    (in_fire),
    .raddr_i (x0 + 1'b1),
    .rdata_o (mid_b_rd)
  );

  csg_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_upper (
    .clk_i   (clk_i),
    .we_i    (s1_vld_q && s1_ctl_q.wr_upper),
    .waddr_i (s1_x_q),
    .wdata_i (c1),
    .re_i    (in_fire),
    .raddr_i (x0),
    .rdata_o (up_rd)
  );

  // stage 1: pick neighbors, run the lanes, merge into one result word
  always_comb begin
    c1 = mid_a_rd;
    r1 = s1_ctl_q.last ? c1 : mid_b_rd;
    u1 = s1_ctl_q.row_zero ? c1 : (s1_ctl_q.fwd ? fwd_data_q : up_rd);
    l1 = s1_ctl_q.x_zero ? c1 : left_q;
    d1 = s1_ctl_q.flush ? c1 : s1_px_q;
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    csg_lane u_lane (
      .c_i (c1[8*k +: 8]),
      .l_i (l1[8*k +: 8]),
      .r_i (r1[8*k +: 8]),
      .u_i (u1[8*k +: 8]),
      .d_i (d1[8*k +: 8]),
      .y_o (y1[8*k +: 8])
    );
  end

  always_comb begin
    res_word.red_out = y1[7:0];
    res_word.green_out = y1[15:8];
    res_word.blue_out = y1[23:16];
    res_word.column_out = 11'(s1_x_q);
    res_word.row_out = s1_ctl_q.row;
    res_word.frame_end = s1_ctl_q.frame_end;
  end

  assign push = s1_vld_q && s1_ctl_q.emit;

  csg_ofifo u_ofifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (res_word),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .count_o     (fifo_cnt)
  );

  assign in_ready_o = (({1'b0, fifo_cnt} + (OFIFO_CW + 1)'(push))
                       < (OFIFO_CW + 1)'(OFIFO_DEPTH));

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fifo_cnt == OFIFO_CW'(OFIFO_DEPTH)) |-> !push)
    else $error("result queue overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && s1_ctl_q.fwd) |-> $past(s1_vld_q && s1_ctl_q.wr_upper))
    else $error("upper store bypass without a pending write");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && s1_ctl_q.frame_end) |-> (s1_ctl_q.emit && s1_ctl_q.last))
    else $error("frame end on a word that is not the last drained column");

endmodule
`default_nettype wire

// File: rtl/core/csg_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module csg_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 2048
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic                                   re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: rtl/core/csg_lane.sv
// One color channel: cross stencil sharpen followed by the gamma curve.
`default_nettype none
module csg_lane (
  input  wire logic [7:0] c_i,
  input  wire logic [7:0] l_i,
  input  wire logic [7:0] r_i,
  input  wire logic [7:0] u_i,
  input  wire logic [7:0] d_i,
  output logic      [7:0] y_o
);

  import csg_pkg::*;

  logic [9:0]  nbr_sum;
  logic [15:0] sharp;

  always_comb begin
    nbr_sum = 10'(l_i) + 10'(u_i) + 10'(r_i) + 10'(d_i);
    sharp = {7'd0, c_i, 1'b0} - {8'd0, nbr_sum[9:2]};
    y_o = (sharp >= 16'd255) ? 8'hFF : GAMMA_ROM[sharp[7:0]];
  end

endmodule
`default_nettype wire

// File: rtl/core/csg_ofifo.sv
// Small output queue that holds finished words until the consumer takes them.
`default_nettype none
module csg_ofifo (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           push_i,
  input  wire csg_pkg::pix_out_t              push_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output csg_pkg::pix_out_t                   out_data_o,
  output logic [csg_pkg::OFIFO_CW-1:0]        count_o
);

  import csg_pkg::*;

  pix_out_t            entries_q [OFIFO_DEPTH];
  logic [OFIFO_PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [OFIFO_PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [OFIFO_CW-1:0] cnt_q, cnt_d;
  logic                pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o = entries_q[rd_ptr_q];
  assign count_o = cnt_q;
  assign pop = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == OFIFO_PW'(OFIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == OFIFO_PW'(OFIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire
